@@ design/pl0ts_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pl0ts_pkg
// Shared types, token and error codes, character constants and the reserved
// word table of the pl0 token scanner.
// ----------------------------------------------------------------------------
package pl0ts_pkg;

  // field widths of the result item
  localparam int TOK_BITS      = 6;
  localparam int ERR_BITS      = 3;
  localparam int LEN_BITS      = 4;
  localparam int NUM_BITS      = 17;
  localparam int LEX_OUT_BYTES = 11;
  localparam int LEX_BITS      = 8 * LEX_OUT_BYTES;
  localparam int LEX_LOW_BITS  = 64;

  // configuration port
  localparam int CFG_IDX_BITS   = 2;
  localparam int CFG_DATA_BITS  = 4;
  localparam int NAME_MAX_BITS  = 4;
  localparam int DIGIT_MAX_BITS = 3;

  localparam logic [CFG_IDX_BITS-1:0]   CFG_NAME_MAX    = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0]   CFG_DIGIT_MAX   = 2'd1;
  localparam logic [NAME_MAX_BITS-1:0]  NAME_MAX_RESET  = 4'd11;
  localparam logic [DIGIT_MAX_BITS-1:0] DIGIT_MAX_RESET = 3'd5;

  // result queue
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_BITS   = 2;
  localparam int CNT_BITS   = 3;

  typedef logic [TOK_BITS-1:0] token_t;
  typedef logic [ERR_BITS-1:0] errc_t;

  // token numbers
  localparam token_t TOK_NONE    = 6'd0;
  localparam token_t TOK_COLON   = 6'd1;   // marks the colon as a known symbol
  localparam token_t TOK_IDENT   = 6'd2;
  localparam token_t TOK_NUMBER  = 6'd3;
  localparam token_t TOK_PLUS    = 6'd4;
  localparam token_t TOK_MINUS   = 6'd5;
  localparam token_t TOK_TIMES   = 6'd6;
  localparam token_t TOK_SLASH   = 6'd7;
  localparam token_t TOK_ODD     = 6'd8;
  localparam token_t TOK_EQL     = 6'd9;
  localparam token_t TOK_NEQ     = 6'd10;
  localparam token_t TOK_LSS     = 6'd11;
  localparam token_t TOK_LEQ     = 6'd12;
  localparam token_t TOK_GTR     = 6'd13;
  localparam token_t TOK_GEQ     = 6'd14;
  localparam token_t TOK_LPAREN  = 6'd15;
  localparam token_t TOK_RPAREN  = 6'd16;
  localparam token_t TOK_COMMA   = 6'd17;
  localparam token_t TOK_SEMI    = 6'd18;
  localparam token_t TOK_PERIOD  = 6'd19;
  localparam token_t TOK_BECOMES = 6'd20;
  localparam token_t TOK_BEGIN   = 6'd21;
  localparam token_t TOK_END     = 6'd22;
  localparam token_t TOK_IF      = 6'd23;
  localparam token_t TOK_THEN    = 6'd24;
  localparam token_t TOK_WHILE   = 6'd25;
  localparam token_t TOK_DO      = 6'd26;
  localparam token_t TOK_CALL    = 6'd27;
  localparam token_t TOK_CONST   = 6'd28;
  localparam token_t TOK_VAR     = 6'd29;
  localparam token_t TOK_PROC    = 6'd30;
  localparam token_t TOK_WRITE   = 6'd31;
  localparam token_t TOK_READ    = 6'd32;
  localparam token_t TOK_ELSE    = 6'd33;

  // error codes
  localparam errc_t ERR_NONE       = 3'd0;
  localparam errc_t ERR_BAD_CHAR   = 3'd1;
  localparam errc_t ERR_LONE_COLON = 3'd2;
  localparam errc_t ERR_NUM_LONG   = 3'd3;
  localparam errc_t ERR_NAME_LONG  = 3'd4;
  localparam errc_t ERR_DIGIT_NAME = 3'd5;

  // characters
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_PERIOD = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_Z   = 8'h7A;

  // reserved words, text right-justified so the first letter sits highest
  localparam int RWORD_COUNT = 14;
  localparam int RWORD_MAX   = 9;

  localparam logic [8*RWORD_MAX-1:0] RWORD_TEXT [RWORD_COUNT] = '{
    "const", "var", "if", "then", "while", "do", "read",
    "write", "odd", "begin", "end", "procedure", "call", "else"
  };
  localparam logic [LEN_BITS-1:0] RWORD_LEN [RWORD_COUNT] = '{
    4'd5, 4'd3, 4'd2, 4'd4, 4'd5, 4'd2, 4'd4,
    4'd5, 4'd3, 4'd5, 4'd3, 4'd9, 4'd4, 4'd4
  };
  localparam token_t RWORD_CODE [RWORD_COUNT] = '{
    TOK_CONST, TOK_VAR, TOK_IF, TOK_THEN, TOK_WHILE, TOK_DO, TOK_READ,
    TOK_WRITE, TOK_ODD, TOK_BEGIN, TOK_END, TOK_PROC, TOK_CALL, TOK_ELSE
  };

  // first character of a two-character operator that waits for its partner
  typedef enum logic [4:0] {
    OP_NONE  = 5'b00001,
    OP_LT    = 5'b00010,
    OP_GT    = 5'b00100,
    OP_COLON = 5'b01000,
    OP_SLASH = 5'b10000
  } op_t;

  typedef struct packed {
    token_t                token_code;
    errc_t                 error_code;
    logic [LEX_BITS-1:0]   lexeme;
    logic [LEN_BITS-1:0]   lexeme_length;
    logic [NUM_BITS-1:0]   number_value;
    logic                  last;
  } result_t;

  // up to two results produced by one item
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

  typedef struct packed {
    logic [NAME_MAX_BITS-1:0]  name_max;
    logic [DIGIT_MAX_BITS-1:0] digit_max;
  } limits_t;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= CH_LO_A && c <= CH_LO_Z) || (c >= CH_UP_A && c <= CH_UP_Z);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic logic is_white(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR;
  endfunction

  function automatic token_t single_code(input logic [7:0] c);
    token_t t;
    unique case (c)
      CH_PLUS:   t = TOK_PLUS;
      CH_MINUS:  t = TOK_MINUS;
      CH_STAR:   t = TOK_TIMES;
      CH_SLASH:  t = TOK_SLASH;
      CH_LPAREN: t = TOK_LPAREN;
      CH_RPAREN: t = TOK_RPAREN;
      CH_EQ:     t = TOK_EQL;
      CH_COMMA:  t = TOK_COMMA;
      CH_PERIOD: t = TOK_PERIOD;
      CH_LT:     t = TOK_LSS;
      CH_GT:     t = TOK_GTR;
      CH_SEMI:   t = TOK_SEMI;
      CH_COLON:  t = TOK_COLON;
      default:   t = TOK_NONE;
    endcase
    return t;
  endfunction

  // reserved word w as a byte array, first letter in byte 0
  function automatic logic [RWORD_MAX-1:0][7:0] rword_bytes(input int w);
    logic [RWORD_MAX-1:0][7:0] b;
    int len;
    b   = '0;
    len = int'(RWORD_LEN[w]);
    for (int k = 0; k < RWORD_MAX; k++) begin
      if (k < len) b[k] = RWORD_TEXT[w][8*(len-1-k) +: 8];
    end
    return b;
  endfunction

  function automatic result_t char_result(input token_t tok, input errc_t err,
                                          input logic [7:0] c);
    result_t r;
    r               = '0;
    r.token_code    = tok;
    r.error_code    = err;
    r.lexeme[7:0]   = c;
    r.lexeme_length = 4'd1;
    return r;
  endfunction

  function automatic result_t pair_result(input token_t tok, input logic [7:0] a,
                                          input logic [7:0] c);
    result_t r;
    r               = '0;
    r.token_code    = tok;
    r.lexeme[7:0]   = a;
    r.lexeme[15:8]  = c;
    r.lexeme_length = 4'd2;
    return r;
  endfunction

endpackage

@@ design/pl0ts_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pl0ts interfaces
// Valid/ready channels of the pl0 token scanner: source characters in,
// tokens out, and the register write port.
// ----------------------------------------------------------------------------
interface pl0ts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       end_of_text;

  modport source (output valid, character, end_of_text, input ready);
  modport sink   (input valid, character, end_of_text, output ready);
endinterface

interface pl0ts_out_if;
  import pl0ts_pkg::*;
  logic                        valid;
  logic                        ready;
  logic [TOK_BITS-1:0]         token_code;
  logic [ERR_BITS-1:0]         error_code;
  logic [LEX_LOW_BITS-1:0]     lexeme_low;
  logic [LEX_BITS-LEX_LOW_BITS-1:0] lexeme_high;
  logic [LEN_BITS-1:0]         lexeme_length;
  logic [NUM_BITS-1:0]         number_value;
  logic                        last;

  modport source (output valid, token_code, error_code, lexeme_low, lexeme_high,
                  lexeme_length, number_value, last, input ready);
  modport sink   (input valid, token_code, error_code, lexeme_low, lexeme_high,
                  lexeme_length, number_value, last, output ready);
endinterface

interface pl0ts_cfg_if;
  import pl0ts_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ design/pl0_token_scanner_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pl0_token_scanner_unit
// PL/0 lexical analyzer: one source byte per item in, tokens out.
// ----------------------------------------------------------------------------
// The scanner takes one character item per clock while the result queue has
// room and produces zero, one or two token items for it; a character that
// ends a word or a pending operator and is itself a symbol gives two tokens,
// which leave the output port one at a time. An accepted item is decided
// while it sits in the input register, its tokens enter the result queue at
// the next edge and the first one is offered from there. The sustained rate
// is one item per cycle, set by the single result port; the input stalls
// only while the four-entry result queue holds more than two tokens.
// Reserved words are matched by fourteen parallel comparators.
// Register 0 sets the longest accepted name, register 1 the most digits in
// a number; write them only while the scanner is idle.
// ----------------------------------------------------------------------------
module pl0_token_scanner_unit #(
  parameter int NAME_STORE_BYTES  = 11,  // bytes of word buffer, 1..16
  parameter int NUMBER_DIGITS_MAX = 5    // digits a number may hold, 1..5
) (
  input  logic           clk,
  input  logic           rst_n,
  pl0ts_in_if.sink       in_chan,
  pl0ts_out_if.source    out_chan,
  pl0ts_cfg_if.sink      cfg_chan
);
  import pl0ts_pkg::*;

  // input register
  logic                      in_v_r;
  logic [7:0]                in_char_r;
  logic                      in_eot_r;
  logic                      fire;
  logic                      room;

  // configuration registers
  logic [NAME_MAX_BITS-1:0]  name_max_r;
  logic [DIGIT_MAX_BITS-1:0] digit_max_r;
  limits_t                   limits;

  push_t                     push;
  result_t                   out_item;

  // the buffered item is decided once the queue can take two tokens
  assign fire          = in_v_r && room;
  assign in_chan.ready = !in_v_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_chan.ready) begin
      in_v_r <= in_chan.valid;
    end
  end

  // payload holds no reset
  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      in_char_r <= in_chan.character;
      in_eot_r  <= in_chan.end_of_text;
    end
  end

  // register writes are always taken; unknown indexes are dropped
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      name_max_r  <= NAME_MAX_RESET;
      digit_max_r <= DIGIT_MAX_RESET;
    end else if (cfg_chan.valid) begin
      unique case (cfg_chan.index)
        CFG_NAME_MAX:  name_max_r  <= cfg_chan.data[NAME_MAX_BITS-1:0];
        CFG_DIGIT_MAX: digit_max_r <= cfg_chan.data[DIGIT_MAX_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign limits.name_max  = name_max_r;
  assign limits.digit_max = digit_max_r;

  // character decision and scanner state
  pl0ts_scan_core #(
    .NAME_STORE_BYTES (NAME_STORE_BYTES),
    .NUMBER_DIGITS_MAX(NUMBER_DIGITS_MAX)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .character  (in_char_r),
    .end_of_text(in_eot_r),
    .limits     (limits),
    .push       (push)
  );

  // tokens wait here for the consumer
  pl0ts_result_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .room     (room),
    .out_valid(out_chan.valid),
    .out_ready(out_chan.ready),
    .out_item (out_item)
  );

  // lexeme splits into the first eight bytes and the rest
  assign out_chan.token_code    = out_item.token_code;
  assign out_chan.error_code    = out_item.error_code;
  assign out_chan.lexeme_low    = out_item.lexeme[LEX_LOW_BITS-1:0];
  assign out_chan.lexeme_high   = out_item.lexeme[LEX_BITS-1:LEX_LOW_BITS];
  assign out_chan.lexeme_length = out_item.lexeme_length;
  assign out_chan.number_value  = out_item.number_value;
  assign out_chan.last          = out_item.last;

endmodule

@@ design/pl0ts_rword_match.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pl0ts_rword_match
// Parallel comparators of the buffered word against the fourteen reserved
// words.
// ----------------------------------------------------------------------------
module pl0ts_rword_match #(
  parameter int NAME_STORE_BYTES = 11,
  parameter int LEN_W            = 4
) (
  input  logic [NAME_STORE_BYTES-1:0][7:0] word,
  input  logic [LEN_W-1:0]                 word_len,
  output logic                             hit,
  output pl0ts_pkg::token_t                code
);
  import pl0ts_pkg::*;

  localparam int VIEW = (NAME_STORE_BYTES < RWORD_MAX) ? NAME_STORE_BYTES : RWORD_MAX;
  localparam int CW   = (LEN_W > LEN_BITS) ? LEN_W : LEN_BITS;

  logic [RWORD_MAX-1:0][7:0] view;
  logic [RWORD_COUNT-1:0]    eq;

  always_comb begin
    view = '0;
    for (int k = 0; k < VIEW; k++) view[k] = word[k];
  end

  // only bytes below the word length take part
  always_comb begin
    for (int w = 0; w < RWORD_COUNT; w++) begin
      logic [RWORD_MAX-1:0][7:0] rw_text;
      rw_text = rword_bytes(w);
      eq[w]   = (CW'(word_len) == CW'(RWORD_LEN[w]));
      for (int k = 0; k < RWORD_MAX; k++) begin
        if (k < int'(RWORD_LEN[w]) && view[k] != rw_text[k]) eq[w] = 1'b0;
      end
    end
  end

  always_comb begin
    code = TOK_NONE;
    for (int w = 0; w < RWORD_COUNT; w++) begin
      if (eq[w]) code = code | RWORD_CODE[w];
    end
  end

  assign hit = |eq;

endmodule

@@ design/pl0ts_scan_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pl0ts_scan_core
// Scanner state and the per-character decision: word buffer, number value,
// pending operator, comment and error flags, and up to two results per item.
// ----------------------------------------------------------------------------
module pl0ts_scan_core #(
  parameter int NAME_STORE_BYTES  = 11,
  parameter int NUMBER_DIGITS_MAX = 5
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  logic [7:0]        character,
  input  logic              end_of_text,
  input  pl0ts_pkg::limits_t limits,
  output pl0ts_pkg::push_t  push
);
  import pl0ts_pkg::*;

  localparam int LEN_CAP   = ((NAME_STORE_BYTES > NUMBER_DIGITS_MAX) ?
                              NAME_STORE_BYTES : NUMBER_DIGITS_MAX) + 1;
  localparam int LW        = $clog2(LEN_CAP + 1);
  localparam int CW        = (LW > LEN_BITS) ? LW : LEN_BITS;
  localparam int STORE_OUT = (NAME_STORE_BYTES < LEX_OUT_BYTES) ?
                             NAME_STORE_BYTES : LEX_OUT_BYTES;

  logic [NAME_STORE_BYTES-1:0][7:0] store_r;
  logic [LW-1:0]       wlen_r, wlen_nxt;
  logic                letter_r, letter_nxt;
  logic [NUM_BITS-1:0] dval_r, dval_nxt;
  op_t                 pend_r, pend_nxt;
  logic                incom_r, incom_nxt;
  logic                star_r, star_nxt;
  logic                err_r, err_nxt;
  logic                store_we;

  logic [CW-1:0]       wlen_x, name_lim, digit_lim, stored;
  logic [LEN_BITS-1:0] out_len;
  logic [LEX_OUT_BYTES-1:0][7:0] word_lex;
  logic                word_busy, flush_err, rw_hit;
  token_t              rw_code;
  result_t             flush_res, first, second;
  logic [1:0]          n;
  logic                go, is_word_char, char_ok;

  pl0ts_rword_match #(
    .NAME_STORE_BYTES(NAME_STORE_BYTES),
    .LEN_W           (LW)
  ) u_rword (
    .word    (store_r),
    .word_len(wlen_r),
    .hit     (rw_hit),
    .code    (rw_code)
  );

  // token that the buffered word turns into when it ends
  always_comb begin
    wlen_x    = CW'(wlen_r);
    name_lim  = (CW'(limits.name_max) > CW'(NAME_STORE_BYTES)) ?
                CW'(NAME_STORE_BYTES) : CW'(limits.name_max);
    digit_lim = (CW'(limits.digit_max) > CW'(NUMBER_DIGITS_MAX)) ?
                CW'(NUMBER_DIGITS_MAX) : CW'(limits.digit_max);
    stored    = (wlen_x > CW'(NAME_STORE_BYTES)) ? CW'(NAME_STORE_BYTES) : wlen_x;
    out_len   = (stored > CW'(LEX_OUT_BYTES)) ? LEN_BITS'(LEX_OUT_BYTES) :
                stored[LEN_BITS-1:0];
    word_busy = (wlen_r != '0);

    word_lex = '0;
    for (int k = 0; k < STORE_OUT; k++) begin
      if (LEN_BITS'(k) < out_len) word_lex[k] = store_r[k];
    end

    flush_res               = '0;
    flush_res.lexeme        = word_lex;
    flush_res.lexeme_length = out_len;
    flush_err               = 1'b0;
    if (is_digit(store_r[0])) begin
      if (letter_r) begin
        flush_res.error_code = ERR_DIGIT_NAME;
        flush_err            = 1'b1;
      end else if (wlen_x > digit_lim) begin
        flush_res.error_code = ERR_NUM_LONG;
        flush_err            = 1'b1;
      end else begin
        flush_res.token_code   = TOK_NUMBER;
        flush_res.number_value = dval_r;
      end
    end else if (wlen_x > name_lim) begin
      flush_res.error_code = ERR_NAME_LONG;
      flush_err            = 1'b1;
    end else begin
      flush_res.token_code = rw_hit ? rw_code : TOK_IDENT;
    end
  end

  assign is_word_char = is_letter(character) || is_digit(character);
  assign char_ok      = is_word_char || is_white(character) ||
                        (single_code(character) != TOK_NONE);

  always_comb begin
    wlen_nxt   = wlen_r;
    letter_nxt = letter_r;
    dval_nxt   = dval_r;
    pend_nxt   = pend_r;
    incom_nxt  = incom_r;
    star_nxt   = star_r;
    err_nxt    = err_r;
    store_we   = 1'b0;
    first      = '0;
    second     = '0;
    n          = 2'd0;
    go         = 1'b0;

    if (end_of_text) begin
      if (!err_r && !incom_r) begin
        unique case (pend_r)
          OP_LT:    begin first = char_result(TOK_LSS, ERR_NONE, CH_LT);   n = 2'd1; end
          OP_GT:    begin first = char_result(TOK_GTR, ERR_NONE, CH_GT);   n = 2'd1; end
          OP_SLASH: begin first = char_result(TOK_SLASH, ERR_NONE, CH_SLASH); n = 2'd1; end
          OP_COLON: begin
            first = char_result(TOK_NONE, ERR_LONE_COLON, CH_COLON);
            n     = 2'd1;
          end
          OP_NONE: begin
            if (word_busy) begin
              first = flush_res;
              n     = 2'd1;
            end
          end
          default: ;
        endcase
      end
      wlen_nxt   = '0;
      letter_nxt = 1'b0;
      dval_nxt   = '0;
      pend_nxt   = OP_NONE;
      incom_nxt  = 1'b0;
      star_nxt   = 1'b0;
      err_nxt    = 1'b0;
    end else if (err_r) begin
      // silent until end of text
    end else if (incom_r) begin
      if (star_r && character == CH_SLASH) incom_nxt = 1'b0;
      star_nxt = (character == CH_STAR);
    end else if (!char_ok) begin
      first   = char_result(TOK_NONE, ERR_BAD_CHAR, character);
      n       = 2'd1;
      err_nxt = 1'b1;
    end else begin
      pend_nxt = OP_NONE;
      go       = 1'b1;
      unique case (pend_r)
        OP_LT: begin
          if (character == CH_EQ) begin
            first = pair_result(TOK_LEQ, CH_LT, CH_EQ);
            go    = 1'b0;
          end else if (character == CH_GT) begin
            first = pair_result(TOK_NEQ, CH_LT, CH_GT);
            go    = 1'b0;
          end else begin
            first = char_result(TOK_LSS, ERR_NONE, CH_LT);
          end
          n = 2'd1;
        end
        OP_GT: begin
          if (character == CH_EQ) begin
            first = pair_result(TOK_GEQ, CH_GT, CH_EQ);
            go    = 1'b0;
          end else begin
            first = char_result(TOK_GTR, ERR_NONE, CH_GT);
          end
          n = 2'd1;
        end
        OP_COLON: begin
          if (character == CH_EQ) begin
            first = pair_result(TOK_BECOMES, CH_COLON, CH_EQ);
          end else begin
            first   = char_result(TOK_NONE, ERR_LONE_COLON, CH_COLON);
            err_nxt = 1'b1;
          end
          n  = 2'd1;
          go = 1'b0;
        end
        OP_SLASH: begin
          if (character == CH_STAR) begin
            incom_nxt = 1'b1;
            star_nxt  = 1'b0;
            go        = 1'b0;
          end else begin
            first = char_result(TOK_SLASH, ERR_NONE, CH_SLASH);
            n     = 2'd1;
          end
        end
        OP_NONE: ;
        default: ;
      endcase

      if (go) begin
        if (is_word_char) begin
          store_we = (wlen_x < CW'(NAME_STORE_BYTES));
          if (is_letter(character)) begin
            letter_nxt = 1'b1;
          end else if (!letter_r && wlen_x < CW'(NUMBER_DIGITS_MAX)) begin
            dval_nxt = (dval_r << 3) + (dval_r << 1) + NUM_BITS'(character - CH_ZERO);
          end
          if (wlen_x < CW'(LEN_CAP)) wlen_nxt = wlen_r + 1'b1;
        end else begin
          wlen_nxt   = '0;
          letter_nxt = 1'b0;
          dval_nxt   = '0;
          if (word_busy) begin
            if (n == 2'd0) first = flush_res;
            else           second = flush_res;
            n = n + 2'd1;
          end
          if (word_busy && flush_err) begin
            err_nxt = 1'b1;
          end else if (is_white(character)) begin
            // separator only
          end else if (character == CH_LT) begin
            pend_nxt = OP_LT;
          end else if (character == CH_GT) begin
            pend_nxt = OP_GT;
          end else if (character == CH_COLON) begin
            pend_nxt = OP_COLON;
          end else if (character == CH_SLASH) begin
            pend_nxt = OP_SLASH;
          end else begin
            if (n == 2'd0) first = char_result(single_code(character), ERR_NONE, character);
            else           second = char_result(single_code(character), ERR_NONE, character);
            n = n + 2'd1;
          end
        end
      end
    end

    first.last  = (n == 2'd1);
    second.last = 1'b1;
  end

  assign push.count  = fire ? n : 2'd0;
  assign push.first  = first;
  assign push.second = second;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlen_r   <= '0;
      letter_r <= 1'b0;
      dval_r   <= '0;
      pend_r   <= OP_NONE;
      incom_r  <= 1'b0;
      star_r   <= 1'b0;
      err_r    <= 1'b0;
    end else if (fire) begin
      wlen_r   <= wlen_nxt;
      letter_r <= letter_nxt;
      dval_r   <= dval_nxt;
      pend_r   <= pend_nxt;
      incom_r  <= incom_nxt;
      star_r   <= star_nxt;
      err_r    <= err_nxt;
    end
  end

  // word bytes, written at the current length
  always_ff @(posedge clk) begin
    for (int k = 0; k < NAME_STORE_BYTES; k++) begin
      if (fire && store_we && wlen_r == LW'(k)) store_r[k] <= character;
    end
  end

endmodule

@@ design/pl0ts_result_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pl0ts_result_fifo
// Small result queue: takes up to two tokens per cycle, hands out one.
// ----------------------------------------------------------------------------
module pl0ts_result_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  pl0ts_pkg::push_t   push,
  output logic               room,
  output logic               out_valid,
  input  logic               out_ready,
  output pl0ts_pkg::result_t out_item
);
  import pl0ts_pkg::*;

  result_t               mem_r [FIFO_DEPTH];
  logic [PTR_BITS-1:0]   wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CNT_BITS-1:0]   cnt_r, cnt_nxt;
  logic                  pop;

  assign out_valid = (cnt_r != '0);
  assign out_item  = mem_r[rp_r];
  assign pop       = out_valid && out_ready;
  assign room      = (cnt_r <= CNT_BITS'(FIFO_DEPTH - 2));

  always_comb begin
    wp_nxt  = wp_r + PTR_BITS'(push.count);
    rp_nxt  = rp_r + PTR_BITS'(pop);
    cnt_nxt = cnt_r + CNT_BITS'(push.count) - CNT_BITS'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) mem_r[wp_r] <= push.first;
    if (push.count == 2'd2) mem_r[wp_r + 1'b1] <= push.second;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

@@ tb/sv/pl0ts_token_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pl0ts_token_checker
// Watches the character, token and register channels of the pl0 token
// scanner, forecasts the tokens of every accepted item and compares each
// accepted token with the oldest one forecast.
// ----------------------------------------------------------------------------
module pl0ts_token_checker (
  input  logic  clk,
  input  logic  rst_n,
  pl0ts_in_if   in_mon,
  pl0ts_out_if  out_mon,
  pl0ts_cfg_if  cfg_mon,
  output int    mismatch_count,
  output int    tokens_pending,
  output int    tokens_checked
);
  import pl0ts_pkg::*;

  localparam int STORE_BYTES = 11;
  localparam int DIGIT_CAP   = 5;
  localparam int LEN_SAT     = STORE_BYTES + 1;

  // scanner state as forecast
  logic [7:0]                word_buf [STORE_BYTES];
  int                        word_len;
  bit                        word_alpha;
  logic [NUM_BITS-1:0]       word_value;
  op_t                       held_op;
  bit                        in_comment;
  bit                        star_seen;
  bit                        err_stuck;
  logic [NAME_MAX_BITS-1:0]  name_limit;
  logic [DIGIT_MAX_BITS-1:0] digit_limit;

  result_t due_tokens [$];
  result_t item_tokens [$];
  int      errors  = 0;
  int      checked = 0;

  function bit alpha_byte(logic [7:0] c);
    return (c >= CH_LO_A && c <= CH_LO_Z) || (c >= CH_UP_A && c <= CH_UP_Z);
  endfunction

  function bit digit_byte(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function bit blank_byte(logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR;
  endfunction

  // colon maps to its marker code so it counts as a known symbol
  function token_t symbol_token(logic [7:0] c);
    case (c)
      CH_PLUS:   return TOK_PLUS;
      CH_MINUS:  return TOK_MINUS;
      CH_STAR:   return TOK_TIMES;
      CH_SLASH:  return TOK_SLASH;
      CH_LPAREN: return TOK_LPAREN;
      CH_RPAREN: return TOK_RPAREN;
      CH_EQ:     return TOK_EQL;
      CH_COMMA:  return TOK_COMMA;
      CH_PERIOD: return TOK_PERIOD;
      CH_LT:     return TOK_LSS;
      CH_GT:     return TOK_GTR;
      CH_SEMI:   return TOK_SEMI;
      CH_COLON:  return TOK_COLON;
      default:   return TOK_NONE;
    endcase
  endfunction

  function void add_token(token_t tok, errc_t err, logic [LEX_BITS-1:0] lex, int n,
                          logic [NUM_BITS-1:0] val);
    result_t r;
    if (item_tokens.size() >= 2) return;
    r               = '0;
    r.token_code    = tok;
    r.error_code    = err;
    r.lexeme        = lex;
    r.lexeme_length = 4'(n);
    r.number_value  = val;
    item_tokens.push_back(r);
  endfunction

  function void flag_error(errc_t err, logic [LEX_BITS-1:0] lex, int n);
    add_token(TOK_NONE, err, lex, n, '0);
    err_stuck = 1'b1;
  endfunction

  function logic [LEX_BITS-1:0] word_lexeme(int n);
    logic [LEX_BITS-1:0] lex;
    lex = '0;
    for (int k = 0; k < n; k++) lex[8*k +: 8] = word_buf[k];
    return lex;
  endfunction

  function logic [LEX_BITS-1:0] pair_lexeme(logic [7:0] a, logic [7:0] b);
    return LEX_BITS'({b, a});
  endfunction

  // reserved words are case sensitive and must match in full
  function token_t word_token(int n);
    string s;
    if (n > STORE_BYTES) return TOK_IDENT;
    s = "";
    for (int k = 0; k < n; k++) s = $sformatf("%s%c", s, word_buf[k]);
    case (s)
      "const":     return TOK_CONST;
      "var":       return TOK_VAR;
      "if":        return TOK_IF;
      "then":      return TOK_THEN;
      "while":     return TOK_WHILE;
      "do":        return TOK_DO;
      "read":      return TOK_READ;
      "write":     return TOK_WRITE;
      "odd":       return TOK_ODD;
      "begin":     return TOK_BEGIN;
      "end":       return TOK_END;
      "procedure": return TOK_PROC;
      "call":      return TOK_CALL;
      "else":      return TOK_ELSE;
      default:     return TOK_IDENT;
    endcase
  endfunction

  function void clear_word();
    word_len   = 0;
    word_alpha = 1'b0;
    word_value = '0;
  endfunction

  function void clear_scan();
    foreach (word_buf[k]) word_buf[k] = '0;
    clear_word();
    held_op    = OP_NONE;
    in_comment = 1'b0;
    star_seen  = 1'b0;
    err_stuck  = 1'b0;
  endfunction

  // closes the word in progress; 0 when that raised an error
  function bit end_word();
    int stored;
    int lim;
    if (word_len == 0) return 1'b1;
    stored = (word_len < STORE_BYTES) ? word_len : STORE_BYTES;
    if (digit_byte(word_buf[0])) begin
      lim = (digit_limit < DIGIT_CAP) ? int'(digit_limit) : DIGIT_CAP;
      if (word_alpha) flag_error(ERR_DIGIT_NAME, word_lexeme(stored), stored);
      else if (word_len > lim) flag_error(ERR_NUM_LONG, word_lexeme(stored), stored);
      else add_token(TOK_NUMBER, ERR_NONE, word_lexeme(stored), stored, word_value);
    end else begin
      lim = (name_limit < STORE_BYTES) ? int'(name_limit) : STORE_BYTES;
      if (word_len > lim) flag_error(ERR_NAME_LONG, word_lexeme(stored), stored);
      else add_token(word_token(word_len), ERR_NONE, word_lexeme(stored), stored, '0);
    end
    clear_word();
    return !err_stuck;
  endfunction

  function void scan_byte(logic [7:0] c);
    op_t was;
    was = held_op;
    if (in_comment) begin
      if (star_seen && c == CH_SLASH) in_comment = 1'b0;
      star_seen = (c == CH_STAR);
      return;
    end
    if (!alpha_byte(c) && !digit_byte(c) && !blank_byte(c) && symbol_token(c) == TOK_NONE)
    begin
      flag_error(ERR_BAD_CHAR, LEX_BITS'(c), 1);
      return;
    end
    held_op = OP_NONE;
    // a waiting first character either pairs up or goes out alone
    case (was)
      OP_LT: begin
        if (c == CH_EQ) begin
          add_token(TOK_LEQ, ERR_NONE, pair_lexeme(CH_LT, c), 2, '0);
          return;
        end
        if (c == CH_GT) begin
          add_token(TOK_NEQ, ERR_NONE, pair_lexeme(CH_LT, c), 2, '0);
          return;
        end
        add_token(TOK_LSS, ERR_NONE, LEX_BITS'(CH_LT), 1, '0);
      end
      OP_GT: begin
        if (c == CH_EQ) begin
          add_token(TOK_GEQ, ERR_NONE, pair_lexeme(CH_GT, c), 2, '0);
          return;
        end
        add_token(TOK_GTR, ERR_NONE, LEX_BITS'(CH_GT), 1, '0);
      end
      OP_COLON: begin
        if (c == CH_EQ) add_token(TOK_BECOMES, ERR_NONE, pair_lexeme(CH_COLON, c), 2, '0);
        else flag_error(ERR_LONE_COLON, LEX_BITS'(CH_COLON), 1);
        return;
      end
      OP_SLASH: begin
        if (c == CH_STAR) begin
          in_comment = 1'b1;
          star_seen  = 1'b0;
          return;
        end
        add_token(TOK_SLASH, ERR_NONE, LEX_BITS'(CH_SLASH), 1, '0);
      end
      default: ;
    endcase
    if (alpha_byte(c) || digit_byte(c)) begin
      if (word_len < STORE_BYTES) word_buf[word_len] = c;
      if (alpha_byte(c)) word_alpha = 1'b1;
      else if (!word_alpha && word_len < DIGIT_CAP)
        word_value = word_value * 10 + NUM_BITS'(c - CH_ZERO);
      if (word_len < LEN_SAT) word_len++;
      return;
    end
    if (!end_word()) return;
    if (blank_byte(c)) return;
    case (c)
      CH_LT:    held_op = OP_LT;
      CH_GT:    held_op = OP_GT;
      CH_COLON: held_op = OP_COLON;
      CH_SLASH: held_op = OP_SLASH;
      default:  add_token(symbol_token(c), ERR_NONE, LEX_BITS'(c), 1, '0);
    endcase
  endfunction

  // end of text flushes what waits unless an error or a comment is open
  function void end_text();
    if (!err_stuck && !in_comment) begin
      case (held_op)
        OP_LT:    add_token(TOK_LSS, ERR_NONE, LEX_BITS'(CH_LT), 1, '0);
        OP_GT:    add_token(TOK_GTR, ERR_NONE, LEX_BITS'(CH_GT), 1, '0);
        OP_SLASH: add_token(TOK_SLASH, ERR_NONE, LEX_BITS'(CH_SLASH), 1, '0);
        OP_COLON: flag_error(ERR_LONE_COLON, LEX_BITS'(CH_COLON), 1);
        default:  void'(end_word());
      endcase
    end
    clear_scan();
  endfunction

  function void scan_item(logic [7:0] c, logic eot);
    result_t r;
    item_tokens.delete();
    if (eot) end_text();
    else if (!err_stuck) scan_byte(c);
    foreach (item_tokens[k]) begin
      r      = item_tokens[k];
      r.last = (k == item_tokens.size() - 1);
      due_tokens.push_back(r);
    end
  endfunction

  function void check_field(string name, logic [LEX_BITS-1:0] want, logic [LEX_BITS-1:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  function void check_token();
    result_t want;
    if (due_tokens.size() == 0) begin
      $display("%0t: token with none expected: code %0d error %0d lexeme %h_%h len %0d",
               $time, out_mon.token_code, out_mon.error_code, out_mon.lexeme_high,
               out_mon.lexeme_low, out_mon.lexeme_length);
      errors++;
      return;
    end
    want = due_tokens.pop_front();
    check_field("token_code", want.token_code, out_mon.token_code);
    check_field("error_code", want.error_code, out_mon.error_code);
    check_field("lexeme_low", want.lexeme[LEX_LOW_BITS-1:0], out_mon.lexeme_low);
    check_field("lexeme_high", want.lexeme[LEX_BITS-1:LEX_LOW_BITS], out_mon.lexeme_high);
    check_field("lexeme_length", want.lexeme_length, out_mon.lexeme_length);
    check_field("number_value", want.number_value, out_mon.number_value);
    check_field("last", want.last, out_mon.last);
    checked++;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_scan();
      name_limit  = NAME_MAX_RESET;
      digit_limit = DIGIT_MAX_RESET;
      due_tokens.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        if (cfg_mon.index == CFG_NAME_MAX) name_limit = cfg_mon.data[NAME_MAX_BITS-1:0];
        else if (cfg_mon.index == CFG_DIGIT_MAX)
          digit_limit = cfg_mon.data[DIGIT_MAX_BITS-1:0];
      end
      if (in_mon.valid && in_mon.ready) scan_item(in_mon.character, in_mon.end_of_text);
      if (out_mon.valid && out_mon.ready) check_token();
    end
    mismatch_count <= errors;
    tokens_pending <= due_tokens.size();
    tokens_checked <= checked;
  end

endmodule

@@ tb/sv/tb_pl0_token_scanner_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pl0_token_scanner_unit
// Feeds the pl0 token scanner with short directed texts and then with random
// PL/0-like texts under several name and digit limits, with random gaps on
// the character side and random stalls on the token side. A checker beside
// the scanner forecasts and compares every token.
// ----------------------------------------------------------------------------
module tb_pl0_token_scanner_unit;
  import pl0ts_pkg::*;

  localparam int                      PHASES    = 7;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE = 2'd3;  // index with no register

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always #5 clk = ~clk;

  pl0ts_in_if  in_chan ();
  pl0ts_out_if out_chan ();
  pl0ts_cfg_if cfg_chan ();

  pl0_token_scanner_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  int mismatch_count;
  int tokens_pending;
  int tokens_checked;

  pl0ts_token_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_chan),
    .out_mon        (out_chan),
    .cfg_mon        (cfg_chan),
    .mismatch_count (mismatch_count),
    .tokens_pending (tokens_pending),
    .tokens_checked (tokens_checked)
  );

  // spelling of the reserved words and symbols for the text generator
  string keyword_list [14] = '{"const", "var", "if", "then", "while", "do", "read",
                               "write", "odd", "begin", "end", "procedure", "call",
                               "else"};
  string pair_list [4] = '{":=", "<>", "<=", ">="};
  string symbol_text   = "+-*/()=,.<>;";

  // register settings per phase: reset values, clamped overflow, smallest,
  // zero, middle, random, back to reset
  logic [CFG_DATA_BITS-1:0] name_set  [PHASES] = '{4'd11, 4'd15, 4'd1, 4'd0, 4'd6, 4'd0, 4'd11};
  logic [CFG_DATA_BITS-1:0] digit_set [PHASES] = '{4'd5, 4'd7, 4'd1, 4'd0, 4'd3, 4'd0, 4'd5};
  int                       phase_len [PHASES] = '{300, 250, 100, 60, 250, 250, 250};

  bit   calm          = 1'b0;  // no idling on either side
  bit   quiet_stretch = 1'b0;  // a text run without idling
  int   stall_left    = 0;
  int   items_sent    = 0;
  int   texts_done    = 0;
  int   settings_used = 1;
  logic sink_ready    = 1'b0;

  assign out_chan.ready = sink_ready;

  // token side stalls in bursts of random length
  always @(posedge clk) begin
    if (stall_left > 0) begin
      sink_ready <= 1'b0;
      stall_left--;
    end else if (!calm && !quiet_stretch && $urandom_range(0, 9) == 0) begin
      sink_ready <= 1'b0;
      stall_left = $urandom_range(0, 16);
    end else begin
      sink_ready <= 1'b1;
    end
  end

  // one character item, with a random gap in front of it now and then
  task automatic feed_char(input logic [7:0] c, input logic eot = 1'b0);
    if (!calm && !quiet_stretch && $urandom_range(0, 11) == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_chan.valid       <= 1'b1;
    in_chan.character   <= c;
    in_chan.end_of_text <= eot;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic feed_text(input string s);
    for (int k = 0; k < s.len(); k++) feed_char(s.getc(k));
  endtask

  function automatic logic [7:0] rand_letter();
    logic [7:0] base;
    base = $urandom_range(0, 1) ? CH_UP_A : CH_LO_A;
    return base + 8'($urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] rand_digit();
    return CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_blank();
    case ($urandom_range(0, 3))
      0:       return CH_TAB;
      1:       return CH_LF;
      2:       return CH_CR;
      default: return CH_SPACE;
    endcase
  endfunction

  // one lexical piece of a text; most are well formed
  task automatic feed_piece();
    int    pick;
    int    n;
    string s;
    pick = $urandom_range(0, 99);
    if (pick < 22) begin
      feed_text(keyword_list[$urandom_range(0, 13)]);
    end else if (pick < 28) begin
      // near miss of a reserved word: case change, cut short or extended
      s = keyword_list[$urandom_range(0, 13)];
      n = $urandom_range(0, s.len() - 1);
      case ($urandom_range(0, 2))
        0:       s.putc(n, s.getc(n) - 8'h20);
        1:       s = s.substr(0, s.len() - 2);
        default: s = {s, "x"};
      endcase
      feed_text(s);
    end else if (pick < 42) begin
      // identifier, now and then past the name store
      n = ($urandom_range(0, 15) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 8);
      feed_char(rand_letter());
      repeat (n - 1) feed_char(($urandom_range(0, 2) == 0) ? rand_digit() : rand_letter());
    end else if (pick < 56) begin
      // number, now and then past the digit limit
      n = ($urandom_range(0, 15) == 0) ? $urandom_range(6, 9) : $urandom_range(1, 5);
      repeat (n) feed_char(rand_digit());
    end else if (pick < 58) begin
      // name led by a digit
      n = $urandom_range(1, 4);
      repeat (n) feed_char(rand_digit());
      feed_char(rand_letter());
    end else if (pick < 76) begin
      feed_char(symbol_text.getc($urandom_range(0, 11)));
    end else if (pick < 84) begin
      feed_text(pair_list[$urandom_range(0, 3)]);
    end else if (pick < 91) begin
      // comment with stars and slashes inside, sometimes left open
      feed_char(CH_SLASH);
      feed_char(CH_STAR);
      n = $urandom_range(0, 8);
      repeat (n) begin
        case ($urandom_range(0, 5))
          0, 1:    feed_char(CH_STAR);
          2:       feed_char(CH_SLASH);
          default: feed_char(8'($urandom_range(0, 255)));
        endcase
      end
      if ($urandom_range(0, 7) != 0) begin
        feed_char(CH_STAR);
        feed_char(CH_SLASH);
      end
    end else if (pick < 97) begin
      n = $urandom_range(1, 3);
      repeat (n) feed_char(rand_blank());
    end else if (pick < 98) begin
      feed_char(CH_COLON);
    end else begin
      feed_char(8'($urandom_range(0, 255)));
    end
  endtask

  // a text of a few pieces closed by end of text
  task automatic feed_segment();
    int pieces;
    pieces        = $urandom_range(1, 16);
    quiet_stretch = ($urandom_range(0, 3) == 0);
    repeat (pieces) begin
      feed_piece();
      if ($urandom_range(0, 9) < 7) feed_char(rand_blank());
    end
    feed_char(8'($urandom_range(0, 255)), 1'b1);
    texts_done++;
  endtask

  // hold the sender until every forecast token is back, then let the
  // pipeline settle since an item may still be in flight without a token
  task automatic drain();
    int guard;
    guard = 0;
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (tokens_pending != 0 && guard < 2000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
  endtask

  // register write; the caller lowers valid after the last one
  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data  <= val;
    @(posedge clk);
    while (!cfg_chan.ready) @(posedge clk);
  endtask

  initial begin
    int goal;
    in_chan.valid       <= 1'b0;
    in_chan.character   <= '0;
    in_chan.end_of_text <= 1'b0;
    cfg_chan.valid      <= 1'b0;
    cfg_chan.index      <= CFG_NAME_MAX;
    cfg_chan.data       <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // a pair, a number, a comment closed by the star-slash inside slash-star-slash,
    // a waiting greater-than flushed by end of text
    feed_text("a<=9/*/*/x*/>");
    feed_char(8'hFF, 1'b1);
    // invalid byte, then the error holds until end of text
    feed_char(8'h00);
    feed_char("x");
    feed_char(8'h00, 1'b1);
    // lone colon
    feed_char(CH_COLON);
    feed_char(CH_TAB);
    feed_char(8'hA5, 1'b1);
    // name led by a digit, ended by end of text
    feed_text("1a");
    feed_char(8'h7F, 1'b1);

    name_set[5]  = 4'($urandom_range(0, 15));
    digit_set[5] = 4'($urandom_range(0, 7));
    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        drain();
        write_reg(CFG_NAME_MAX, name_set[p]);
        write_reg(CFG_DIGIT_MAX, digit_set[p]);
        // a write to the unused index must leave both limits alone
        if (p == 4) write_reg(CFG_SPARE, 4'hF);
        cfg_chan.valid <= 1'b0;
        @(posedge clk);
        settings_used++;
      end
      calm = (p == PHASES - 1);
      goal = items_sent + phase_len[p];
      while (items_sent < goal) feed_segment();
    end
    drain();

    if (tokens_pending != 0)
      $display("%0t: %0d forecast tokens never arrived", $time, tokens_pending);
    $display("covered %0d characters in %0d texts under %0d limit settings", items_sent,
             texts_done, settings_used);
    $display("compared %0d tokens, %0d mismatches", tokens_checked, mismatch_count);
    if (mismatch_count == 0 && tokens_pending == 0) begin
      $display("tb_pl0_token_scanner_unit: done, clean");
    end else begin
      $display("tb_pl0_token_scanner_unit: done, errors");
    end
    $finish;
  end

  // hang guard, several times the slowest legal run
  initial begin
    #(5_000_000);
    $display("tb_pl0_token_scanner_unit: done, errors");
    $finish;
  end

endmodule

@@ sim.f @@
design/pl0ts_pkg.sv
design/pl0ts_if.sv
design/pl0ts_rword_match.sv
design/pl0ts_scan_core.sv
design/pl0ts_result_fifo.sv
design/pl0_token_scanner_unit.sv
tb/sv/pl0ts_token_checker.sv
tb/sv/tb_pl0_token_scanner_unit.sv
